@@ rtl/core/crc32_image_lookup_macros.svh @@
// ----------------------------------------------------------------------------
// crc32_image_lookup assertion macros
// Concurrent checks for the image lookup block, clocked on clk and held
// off while rst_n is low. They compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef CRC32_IMAGE_LOOKUP_MACROS_SVH
`define CRC32_IMAGE_LOOKUP_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define CRC32IL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CRC32IL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define CRC32IL_ASSERT_SAME(lbl, ante, cons, msg)
`define CRC32IL_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ rtl/core/crc32il_pkg.sv @@
// ----------------------------------------------------------------------------
// crc32il_pkg
// Types and constants shared by the image lookup block and its reference
// table memory, and the byte-wise CRC-32 step the lookup block uses.
// ----------------------------------------------------------------------------
`default_nettype none

package crc32il_pkg;

  // Reference table geometry.
  localparam int TABLE_DEPTH = 4096;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Field widths fixed by the interface.
  localparam int COUNT_W = 13;
  localparam int INDEX_W = 12;
  localparam int CRC_W   = 32;
  localparam int BYTE_W  = 8;

  // Reflected CRC-32 constants.
  localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [CRC_W-1:0] CRC_XOUT = 32'hFFFF_FFFF;

  // Request kinds carried in req_type.
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_DATA = 1'b1;

  // Input word.
  typedef struct packed {
    logic               req_type;
    logic [INDEX_W-1:0] entry_index;
    logic [CRC_W-1:0]   entry_crc;
    logic [BYTE_W-1:0]  data_byte;
    logic               last_byte;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] match_index;
    logic [CRC_W-1:0]   image_crc;
  } out_word_t;

  // Table write port.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [CRC_W-1:0]  data;
  } tbl_wr_t;

  // Table read request.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } tbl_rd_t;

  // Control sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // One byte through the reflected CRC register.
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] c,
                                               input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] x;
    x = {{(CRC_W-BYTE_W){1'b0}}, c[BYTE_W-1:0] ^ b};
    for (int k = 0; k < BYTE_W; k++) begin
      if (x[0]) begin
        x = CRC_POLY ^ (x >> 1);
      end else begin
        x = x >> 1;
      end
    end
    return x ^ (c >> BYTE_W);
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/crc32il_table.sv @@
// ----------------------------------------------------------------------------
// crc32il_table
// Reference CRC table: one synchronous write port and one synchronous read
// port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module crc32il_table (
  input  wire                              clk,
  input  crc32il_pkg::tbl_wr_t             wr,
  input  crc32il_pkg::tbl_rd_t             rd,
  output logic [crc32il_pkg::CRC_W-1:0]    rd_data
);

  logic [crc32il_pkg::CRC_W-1:0] mem [crc32il_pkg::TABLE_DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Read port, with registered read data.
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/crc32_image_lookup.sv @@
// ----------------------------------------------------------------------------
// crc32_image_lookup
// Identifies a program image by its reflected CRC-32 and a table of
// reference checksums.
// ----------------------------------------------------------------------------
// Load words and data bytes are taken one per cycle while in_stall is low.
// A load word writes one entry of the reference table; a data byte advances
// the running CRC. The byte marked last closes the image: the block then
// stalls its input and scans the table from entry 0 through one read port,
// one entry per cycle, stopping at the first match. A miss searches
// min(entry_count, 4096) entries; an entry_count of 0 skips the scan. The
// result sits in an output register, so input keeps flowing while it waits
// to be taken; only the next image close waits for that register to free
// up, stalling the input meanwhile. The user must see that entry_count is
// written through the cfg port only while no image close is in flight; the
// block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

`include "crc32_image_lookup_macros.svh"

module crc32_image_lookup (
  input  wire                                   clk,
  input  wire                                   rst_n,
  // Input words.
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  crc32il_pkg::in_word_t                 in_data,
  // Result words.
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output crc32il_pkg::out_word_t                out_data,
  // Configuration: entry_count.
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire [crc32il_pkg::COUNT_W-1:0]        cfg_data
);

  // Registers.
  crc32il_pkg::state_t                 state_r, state_nxt;
  logic [crc32il_pkg::CRC_W-1:0]       crc_r, crc_nxt;
  logic [crc32il_pkg::CRC_W-1:0]       final_r;
  logic [crc32il_pkg::COUNT_W-1:0]     entry_count_r;
  logic [crc32il_pkg::CNT_W-1:0]       issue_cnt_r;
  logic                                rd_pend_r;
  logic [crc32il_pkg::ADDR_W-1:0]      cmp_idx_r;
  logic                                hit_r;
  logic [crc32il_pkg::ADDR_W-1:0]      hit_idx_r;
  logic                                out_valid_r;
  crc32il_pkg::out_word_t              out_data_r;

  // Combinational control.
  logic                                in_take;
  logic                                img_close;
  logic [crc32il_pkg::CNT_W-1:0]       limit;
  logic                                match_now;
  logic                                miss_end;
  logic                                issue;
  logic                                load_out;
  crc32il_pkg::tbl_wr_t                tbl_wr;
  crc32il_pkg::tbl_rd_t                tbl_rd;
  logic [crc32il_pkg::CRC_W-1:0]       tbl_rd_data;

  // Handshake terms.
  assign in_take   = in_valid && !in_stall;
  assign img_close = in_take && (in_data.req_type == crc32il_pkg::REQ_DATA)
                     && in_data.last_byte;
  assign cfg_ready = 1'b1;

  // Number of entries searched, clipped to the table depth.
  always_comb begin
    if (32'(entry_count_r) > 32'(crc32il_pkg::TABLE_DEPTH)) begin
      limit = crc32il_pkg::CNT_W'(crc32il_pkg::TABLE_DEPTH);
    end else begin
      limit = crc32il_pkg::CNT_W'(entry_count_r);
    end
  end

  // Compare the entry read in the previous cycle against the image CRC.
  assign match_now = rd_pend_r && (tbl_rd_data == final_r);
  assign miss_end  = rd_pend_r && !match_now
                     && (crc32il_pkg::CNT_W'(cmp_idx_r) == limit - 1'b1);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      crc32il_pkg::ST_IDLE: begin
        if (img_close) begin
          state_nxt = (limit == '0) ? crc32il_pkg::ST_DONE : crc32il_pkg::ST_SCAN;
        end
      end
      crc32il_pkg::ST_SCAN: begin
        if (match_now || miss_end) begin
          state_nxt = crc32il_pkg::ST_DONE;
        end
      end
      crc32il_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = crc32il_pkg::ST_IDLE;
        end
      end
      default: state_nxt = crc32il_pkg::ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_stall = 1'b1;
    issue    = 1'b0;
    load_out = 1'b0;
    unique case (state_r)
      crc32il_pkg::ST_IDLE: begin
        in_stall = 1'b0;
      end
      crc32il_pkg::ST_SCAN: begin
        issue = (issue_cnt_r < limit);
      end
      crc32il_pkg::ST_DONE: begin
        load_out = !out_valid_r || !out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // Table ports: loads write, the scan reads.
  always_comb begin
    tbl_wr.en   = in_take && (in_data.req_type == crc32il_pkg::REQ_LOAD)
                  && (32'(in_data.entry_index) < 32'(crc32il_pkg::TABLE_DEPTH));
    tbl_wr.addr = crc32il_pkg::ADDR_W'(in_data.entry_index);
    tbl_wr.data = in_data.entry_crc;
    tbl_rd.en   = issue;
    tbl_rd.addr = issue_cnt_r[crc32il_pkg::ADDR_W-1:0];
  end

  crc32il_table u_table (
    .clk     (clk),
    .wr      (tbl_wr),
    .rd      (tbl_rd),
    .rd_data (tbl_rd_data)
  );

  // Running CRC: advance on data bytes, reopen after the last one.
  always_comb begin
    crc_nxt = crc_r;
    if (in_take && (in_data.req_type == crc32il_pkg::REQ_DATA)) begin
      if (in_data.last_byte) begin
        crc_nxt = crc32il_pkg::CRC_INIT;
      end else begin
        crc_nxt = crc32il_pkg::crc_byte(crc_r, in_data.data_byte);
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= crc32il_pkg::ST_IDLE;
      crc_r         <= crc32il_pkg::CRC_INIT;
      entry_count_r <= '0;
      rd_pend_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      crc_r   <= crc_nxt;
      if (cfg_valid && cfg_ready) begin
        entry_count_r <= cfg_data;
      end
      rd_pend_r <= issue;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Scan and result datapath.
  always_ff @(posedge clk) begin
    if (img_close) begin
      final_r     <= crc32il_pkg::crc_byte(crc_r, in_data.data_byte)
                     ^ crc32il_pkg::CRC_XOUT;
      issue_cnt_r <= '0;
      hit_r       <= 1'b0;
      hit_idx_r   <= '0;
    end else begin
      if (issue) begin
        issue_cnt_r <= issue_cnt_r + 1'b1;
      end
      if (state_r == crc32il_pkg::ST_SCAN && match_now) begin
        hit_r     <= 1'b1;
        hit_idx_r <= cmp_idx_r;
      end
    end
    if (issue) begin
      cmp_idx_r <= issue_cnt_r[crc32il_pkg::ADDR_W-1:0];
    end
    if (load_out) begin
      out_data_r.found       <= hit_r;
      out_data_r.match_index <= crc32il_pkg::INDEX_W'(hit_idx_r);
      out_data_r.image_crc   <= final_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks.
  `CRC32IL_ASSERT_NEXT(a_crc_reopens, img_close, crc_r == crc32il_pkg::CRC_INIT, "CRC register not reopened after last byte")
  `CRC32IL_ASSERT_SAME(a_hit_in_range, load_out && hit_r, 32'(hit_idx_r) < 32'(limit), "Match index beyond searched entries")
  `CRC32IL_ASSERT_SAME(a_out_from_done, $rose(out_valid_r), $past(state_r) == crc32il_pkg::ST_DONE, "Result raised outside result state")

endmodule

`default_nettype wire
